/* src/single_source_shortest_path_top_assert.svh */
// Assertion macros for the shortest path RTL.
// Uses the clk and rst_n names of the including module; no other dependencies.
`ifndef SINGLE_SOURCE_SHORTEST_PATH_TOP_ASSERT_SVH
`define SINGLE_SOURCE_SHORTEST_PATH_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SSSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SSSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/sssp_pkg.sv */
// Shared types and constants for the shortest path block.
// No dependencies.
package sssp_pkg;

  localparam int NODE_W = 4;
  localparam int EWGT_W = 16;
  localparam int DIST_W = 20;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RUN  = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
    logic [EWGT_W-1:0] edge_weight;
    logic [NODE_W-1:0] source;
  } sssp_in_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [DIST_W-1:0] distance;
    logic              reachable;
    logic              last;
  } sssp_out_t;

endpackage

/* src/sssp_wmem.sv */
// Adjacency matrix store: NODES*NODES weights, one write and one registered read port.
// Clears itself after reset, one entry per cycle. No package dependencies.
module sssp_wmem #(
  parameter int NODES       = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 wr_en,
  input  logic [$clog2(NODES*NODES)-1:0]       wr_addr,
  input  logic [WEIGHT_BITS-1:0]               wr_data,
  input  logic [$clog2(NODES*NODES)-1:0]       rd_addr,
  output logic [WEIGHT_BITS-1:0]               rd_data,
  output logic                                 clearing
);

  localparam int AW = $clog2(NODES*NODES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NODES*NODES-1);

  logic [WEIGHT_BITS-1:0] mem [NODES*NODES];
  logic                   clr_act_r, clr_act_nxt;
  logic [AW-1:0]          clr_idx_r, clr_idx_nxt;

  always_comb begin
    clr_act_nxt = clr_act_r;
    clr_idx_nxt = clr_idx_r;
    if (clr_act_r) begin
      clr_idx_nxt = clr_idx_r + 1'b1;
      if (clr_idx_r == LAST_ADDR) begin
        clr_act_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_act_r <= 1'b1;
      clr_idx_r <= '0;
    end else begin
      clr_act_r <= clr_act_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  // sweep owns the write port until done
  always_ff @(posedge clk) begin
    if (clr_act_r) begin
      mem[clr_idx_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign clearing = clr_act_r;

endmodule

/* src/sssp_dmem.sv */
// Per-node distance store: simple one write, one registered read port RAM.
// No package dependencies.
module sssp_dmem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 20
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* src/single_source_shortest_path_top.sv */
// Shortest path top level: request decode, search sequencer and result register.
// Depends on sssp_pkg, sssp_wmem, sssp_dmem and single_source_shortest_path_top_assert.svh.
//
//  channel  | ports                    | handshake
//  ---------+--------------------------+----------------------------------------
//  request  | start, busy, in_data     | taken on a clock edge with start & !busy
//  result   | out_valid, out_data      | one result per cycle, no back-pressure
//
// A load request writes one weight; loads can stream back to back. After a run
// request is taken, busy stays high while the sequencer alternates select and relax
// passes, one pair per node reached, then makes a last select pass and an output pass.
// Each pass of the sequencer walks all nodes through the one read port of the distance
// RAM (and the weight RAM on relax). After reset the weight RAM is swept to zero with
// busy high. Results of a run come out on consecutive cycles, one per node; the last
// one is flagged, and busy drops in that same cycle.
module single_source_shortest_path_top #(
  parameter int NODES       = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  sssp_pkg::sssp_in_t   in_data,
  output logic                 busy,
  output logic                 out_valid,
  output sssp_pkg::sssp_out_t  out_data
);

  import sssp_pkg::*;

  `include "single_source_shortest_path_top_assert.svh"

  localparam int IW    = $clog2(NODES);
  localparam int AW    = $clog2(NODES*NODES);
  localparam int CMP_W = (NODE_W > IW + 1) ? NODE_W : IW + 1;
  localparam int SUM_W = ((DIST_W > WEIGHT_BITS) ? DIST_W : WEIGHT_BITS) + 1;
  localparam logic [IW-1:0] IDX_LAST = IW'(NODES-1);

  // search sequencer
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SEL   = 4'b0010,  // scan for nearest open node
    ST_RELAX = 4'b0100,  // walk its weight row
    ST_OUT   = 4'b1000   // stream results
  } state_t;

  state_t state_r, state_nxt;

  // node walk: the issue stage (idx) feeds the evaluate stage (ev) through one register,
  // lined up with the registered RAM read data
  logic            iss_r, iss_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic            ev_vld_r, ev_vld_nxt;
  logic [IW-1:0]   ev_idx_r, ev_idx_nxt;
  logic            ev_last;

  logic              found_r, found_nxt;
  logic [IW-1:0]     cur_r, cur_nxt;
  logic [DIST_W-1:0] best_r, best_nxt;   // distance of cur during relax

  logic [NODES-1:0]  reached_r, reached_nxt;
  logic [NODES-1:0]  done_r, done_nxt;

  logic      out_valid_r, out_valid_nxt;
  sssp_out_t out_data_r, out_data_nxt;

  // RAM ports
  logic                   dm_we;
  logic [IW-1:0]          dm_waddr;
  logic [DIST_W-1:0]      dm_wdata;
  logic [DIST_W-1:0]      dm_rdata;
  logic                   wm_we;
  logic [AW-1:0]          wm_waddr;
  logic [WEIGHT_BITS-1:0] wm_wdata;
  logic [AW-1:0]          wm_raddr;
  logic [WEIGHT_BITS-1:0] wm_rdata;
  logic                   clearing;

  // request decode
  logic          accept;
  logic          from_ok, to_ok, src_ok;
  logic [IW-1:0] from_idx, to_idx, src_idx;

  // relax arithmetic
  logic [SUM_W-1:0]  sum;
  logic [DIST_W-1:0] cand;
  logic              relax_take;

  sssp_wmem #(
    .NODES       (NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_wmem (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wm_we),
    .wr_addr  (wm_waddr),
    .wr_data  (wm_wdata),
    .rd_addr  (wm_raddr),
    .rd_data  (wm_rdata),
    .clearing (clearing)
  );

  sssp_dmem #(
    .DEPTH (NODES),
    .WIDTH (DIST_W)
  ) u_dmem (
    .clk     (clk),
    .wr_en   (dm_we),
    .wr_addr (dm_waddr),
    .wr_data (dm_wdata),
    .rd_addr (idx_r),
    .rd_data (dm_rdata)
  );

  assign busy   = (state_r != ST_IDLE) || clearing;
  assign accept = start && !busy;

  // out-of-range indexes: load dropped, run reaches nothing
  assign from_ok  = CMP_W'(in_data.from_node) < CMP_W'(NODES);
  assign to_ok    = CMP_W'(in_data.to_node) < CMP_W'(NODES);
  assign src_ok   = CMP_W'(in_data.source) < CMP_W'(NODES);
  assign from_idx = IW'(in_data.from_node);
  assign to_idx   = IW'(in_data.to_node);
  assign src_idx  = IW'(in_data.source);

  // row of the node being relaxed; the constant multiply stays small
  assign wm_raddr = AW'(cur_r) * AW'(NODES) + AW'(idx_r);

  // candidate distance, saturating at the 20-bit maximum
  assign sum  = SUM_W'(best_r) + SUM_W'(wm_rdata);
  assign cand = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(sum);

  // zero weight means no edge; self loops never win since cand >= best
  assign relax_take = (wm_rdata != '0) && (!reached_r[ev_idx_r] || (cand < dm_rdata));

  assign ev_last = ev_vld_r && (ev_idx_r == IDX_LAST);

  always_comb begin
    state_nxt     = state_r;
    iss_nxt       = iss_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    cur_nxt       = cur_r;
    best_nxt      = best_r;
    reached_nxt   = reached_r;
    done_nxt      = done_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    dm_we         = 1'b0;
    dm_waddr      = ev_idx_r;
    dm_wdata      = cand;
    wm_we         = 1'b0;
    wm_waddr      = AW'(from_idx) * AW'(NODES) + AW'(to_idx);
    wm_wdata      = WEIGHT_BITS'(in_data.edge_weight);

    // walk pipeline
    ev_vld_nxt = iss_r;
    ev_idx_nxt = idx_r;
    if (iss_r) begin
      if (idx_r == IDX_LAST) begin
        iss_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.mode == MODE_LOAD) begin
            wm_we = from_ok && to_ok;
          end else begin
            reached_nxt = '0;
            done_nxt    = '0;
            found_nxt   = 1'b0;
            if (src_ok) begin
              reached_nxt[src_idx] = 1'b1;
              dm_we                = 1'b1;
              dm_waddr             = src_idx;
              dm_wdata             = '0;
            end
            state_nxt = ST_SEL;
            idx_nxt   = '0;
            iss_nxt   = 1'b1;
          end
        end
      end
      ST_SEL: begin
        // strict less-than keeps the lowest index on ties
        if (ev_vld_r && reached_r[ev_idx_r] && !done_r[ev_idx_r] &&
            (!found_r || (dm_rdata < best_r))) begin
          found_nxt = 1'b1;
          best_nxt  = dm_rdata;
          cur_nxt   = ev_idx_r;
        end
        if (ev_last) begin
          if (found_nxt) begin
            done_nxt[cur_nxt] = 1'b1;
            state_nxt         = ST_RELAX;
          end else begin
            state_nxt = ST_OUT;
          end
          idx_nxt = '0;
          iss_nxt = 1'b1;
        end
      end
      ST_RELAX: begin
        // write of node i overlaps the read of node i+1; on the last node the read hits the same entry but is unused
        if (ev_vld_r && relax_take) begin
          dm_we                 = 1'b1;
          reached_nxt[ev_idx_r] = 1'b1;
        end
        if (ev_last) begin
          found_nxt = 1'b0;
          state_nxt = ST_SEL;
          idx_nxt   = '0;
          iss_nxt   = 1'b1;
        end
      end
      ST_OUT: begin
        if (ev_vld_r) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.node      = NODE_W'(ev_idx_r);
          out_data_nxt.distance  = reached_r[ev_idx_r] ? dm_rdata : '0;
          out_data_nxt.reachable = reached_r[ev_idx_r];
          out_data_nxt.last      = (ev_idx_r == IDX_LAST);
        end
        if (ev_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iss_r       <= 1'b0;
      ev_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      reached_r   <= '0;
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      ev_vld_r    <= ev_vld_nxt;
      found_r     <= found_nxt;
      reached_r   <= reached_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    ev_idx_r   <= ev_idx_nxt;
    cur_r      <= cur_nxt;
    best_r     <= best_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // the final result of a run coincides with the sequencer going idle
  `SSSP_ASSERT_NOW(a_last_idle, out_valid_r && out_data_r.last, state_r == ST_IDLE, "last result while sequencer active")
  // a finished node must have been reached
  `SSSP_ASSERT_NOW(a_done_reached, 1'b1, (done_r & ~reached_r) == '0, "finished node not reached")
  // within a run the finished set only grows
  `SSSP_ASSERT_NEXT(a_done_grows, state_r != ST_IDLE, (done_r & $past(done_r)) == $past(done_r), "finished node lost during run")
  // a relax write marks its node reached
  `SSSP_ASSERT_NEXT(a_relax_mark, (state_r == ST_RELAX) && dm_we, reached_r[$past(ev_idx_r)], "relaxed node not marked reached")

endmodule

/* tb/single_source_shortest_path_top_tb.sv */
// Self-checking testbench for single_source_shortest_path_top: weight loads and searches go in
// through start/busy, and every node result is checked against a local shortest path predictor.
// Depends on sssp_pkg and the RTL of single_source_shortest_path_top.
`timescale 1ns / 1ps

module single_source_shortest_path_top_tb;
  import sssp_pkg::*;

  localparam int NODES        = 16;
  localparam int DRAIN_CYCLES = 600;  // outlasts the longest search: 2*16+2 passes over all nodes
  localparam int REPORT_MAX   = 10;
  localparam int IN_W         = $bits(sssp_in_t);

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  sssp_in_t  in_data = '0;
  logic      busy;
  logic      out_valid;
  sssp_out_t out_data;

  // Local copy of the adjacency matrix, updated as each load request is accepted.
  logic [EWGT_W-1:0] edge_wgt [NODES][NODES];
  // Node results still owed by the block, oldest first.
  sssp_out_t         node_result_q [$];

  int unsigned err_cnt    = 0;
  int unsigned load_cnt   = 0;
  int unsigned search_cnt = 0;
  int unsigned result_cnt = 0;
  int unsigned idle_pct   = 0;  // chance in percent that the sender skips a cycle

  single_source_shortest_path_top #(
    .NODES       (NODES),
    .WEIGHT_BITS (EWGT_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs with busy high or never finishes a search.
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Array form of Dijkstra: settle the nearest reached node (lowest index on a tie),
  // then relax its row. A zero weight is no edge. Queues one result per node.
  function automatic void push_shortest_paths(input logic [NODE_W-1:0] src);
    logic [DIST_W-1:0] node_dist [NODES];
    bit                reached   [NODES];
    bit                settled   [NODES];
    int                cur;
    logic [DIST_W:0]   cand;
    sssp_out_t         res;
    for (int i = 0; i < NODES; i++) begin
      node_dist[i] = '0;
      reached[i]   = 1'b0;
      settled[i]   = 1'b0;
    end
    reached[src] = 1'b1;
    for (int round = 0; round < NODES; round++) begin
      cur = -1;
      for (int i = 0; i < NODES; i++) begin
        if (reached[i] && !settled[i] && (cur < 0 || node_dist[i] < node_dist[cur])) cur = i;
      end
      if (cur < 0) break;
      settled[cur] = 1'b1;
      for (int i = 0; i < NODES; i++) begin
        if (edge_wgt[cur][i] != '0) begin
          cand = {1'b0, node_dist[cur]} + edge_wgt[cur][i];
          if (cand > DIST_MAX) cand = DIST_MAX;  // saturate, unreachable at 16 nodes
          // A self loop never wins: cand is never below node_dist[cur].
          if (!reached[i] || cand[DIST_W-1:0] < node_dist[i]) begin
            node_dist[i] = cand[DIST_W-1:0];
            reached[i]   = 1'b1;
          end
        end
      end
    end
    for (int i = 0; i < NODES; i++) begin
      res.node      = NODE_W'(i);
      res.distance  = reached[i] ? node_dist[i] : '0;
      res.reachable = reached[i];
      res.last      = (i == NODES - 1);
      node_result_q.push_back(res);
    end
  endfunction

  // Drives one request from a falling edge and holds it until taken (start & !busy).
  // Idle cycles put random junk on in_data with start low; it must be ignored.
  task automatic send_req(input sssp_in_t req);
    @(negedge clk);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start   = 1'b0;
      in_data = IN_W'($urandom);
      @(negedge clk);
    end
    start   = 1'b1;
    in_data = req;
    do @(posedge clk); while (busy);
    // Accepted at this edge; start stays high until the next falling edge.
    if (req.mode == MODE_LOAD) begin
      edge_wgt[req.from_node][req.to_node] = req.edge_weight;
      load_cnt++;
    end else begin
      push_shortest_paths(req.source);
      search_cnt++;
    end
  endtask

  task automatic load_edge(input logic [NODE_W-1:0] from_n, input logic [NODE_W-1:0] to_n,
                           input logic [EWGT_W-1:0] wgt);
    sssp_in_t req;
    req             = IN_W'($urandom);  // source field is don't-care on a load
    req.mode        = MODE_LOAD;
    req.from_node   = from_n;
    req.to_node     = to_n;
    req.edge_weight = wgt;
    send_req(req);
  endtask

  task automatic run_from(input logic [NODE_W-1:0] src);
    sssp_in_t req;
    req        = IN_W'($urandom);  // edge fields are don't-care on a search
    req.mode   = MODE_RUN;
    req.source = src;
    send_req(req);
  endtask

  // Small weights so paths compete, plus deletions, full-scale and random values.
  function automatic logic [EWGT_W-1:0] pick_weight();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return '0;
    if (r < 60) return EWGT_W'($urandom_range(1, 15));
    if (r < 68) return '1;
    if (r < 78) return EWGT_W'($urandom) | {1'b1, {(EWGT_W-1){1'b0}}};
    return EWGT_W'($urandom);
  endfunction

  // Nothing loaded yet: only the source itself is reachable, at distance zero.
  task automatic test_empty_graph();
    run_from('0);
    run_from('1);
  endtask

  // Chain of heaviest edges 0 -> 1 -> ... -> 15: node 15 sits at the largest distance.
  task automatic test_long_chain();
    for (int i = 0; i < NODES - 1; i++) load_edge(NODE_W'(i), NODE_W'(i + 1), '1);
    run_from('0);
  endtask

  // Self loop, a shortcut that beats the chain, a deleted edge that cuts it,
  // and an edge back into node 0 so node 15 becomes a useful source.
  task automatic test_edge_updates();
    load_edge(4'd15, 4'd15, 16'd1);
    load_edge(4'd0, 4'd2, 16'd1);
    load_edge(4'd7, 4'd8, '0);
    load_edge(4'd15, 4'd0, 16'd1);
    run_from(4'd0);
    run_from(4'd15);
  endtask

  // Episodes of a few random loads followed by a search; sometimes a whole row
  // is wiped to keep the graph sparse, sometimes searches come back to back.
  task automatic test_random_graphs(input int unsigned n_items, input int unsigned pct);
    int unsigned         sent;
    int unsigned         n_loads;
    logic [NODE_W-1:0]   row;
    idle_pct = pct;
    sent     = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 8) begin
        row = NODE_W'($urandom);
        for (int c = 0; c < NODES; c++) load_edge(row, NODE_W'(c), '0);
        sent += NODES;
      end else begin
        n_loads = $urandom_range(0, 8);
        repeat (n_loads) load_edge(NODE_W'($urandom), NODE_W'($urandom), pick_weight());
        sent += n_loads;
      end
      run_from(NODE_W'($urandom));
      sent++;
    end
  endtask

  // Results cannot be held off, so every strobe is checked at the edge that ends it.
  always @(posedge clk) begin : check_results
    sssp_out_t exp_res;
    if (rst_n && out_valid) begin
      if (node_result_q.size() == 0) begin
        if (err_cnt < REPORT_MAX)
          $display("%0t: unexpected result node %0d dist %0d reach %0b last %0b", $realtime,
                   out_data.node, out_data.distance, out_data.reachable, out_data.last);
        err_cnt++;
      end else begin
        exp_res = node_result_q.pop_front();
        result_cnt++;
        if (out_data.node !== exp_res.node || out_data.distance !== exp_res.distance ||
            out_data.reachable !== exp_res.reachable || out_data.last !== exp_res.last) begin
          if (err_cnt < REPORT_MAX)
            $display("%0t: mismatch exp node %0d dist %0d reach %0b last %0b, got node %0d dist %0d reach %0b last %0b",
                     $realtime, exp_res.node, exp_res.distance, exp_res.reachable, exp_res.last,
                     out_data.node, out_data.distance, out_data.reachable, out_data.last);
          err_cnt++;
        end
      end
    end
  end

  initial begin : main_seq
    int unsigned spin;
    for (int r = 0; r < NODES; r++)
      for (int c = 0; c < NODES; c++) edge_wgt[r][c] = '0;

    // Synchronous reset, released at a falling edge; the block then clears its weight RAM
    // with busy high, which send_req simply waits out.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    idle_pct = 0;
    test_empty_graph();
    test_long_chain();
    test_edge_updates();

    test_random_graphs(150, 0);
    test_random_graphs(150, 82);
    test_random_graphs(140, 24);

    @(negedge clk);
    start   = 1'b0;
    in_data = '0;

    // Let the last search finish, then watch a while longer for stray strobes.
    spin = 0;
    while (node_result_q.size() != 0 && spin < 20 * DRAIN_CYCLES) begin
      @(posedge clk);
      spin++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (node_result_q.size() != 0) begin
      $display("%0d node results never arrived", node_result_q.size());
      err_cnt++;
    end

    $display("Sent %0d weight loads and %0d searches, checked %0d node results.",
             load_cnt, search_cnt, result_cnt);
    $display("Sender idle phases: none, 82 and 24 percent; %0d failures seen.", err_cnt);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
